// ===== rtl/touch_sample_average_scale_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the touch sample average and scale block
// Shared concurrent assertion macros; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef TOUCH_SAMPLE_AVERAGE_SCALE_ASSERT_SVH
`define TOUCH_SAMPLE_AVERAGE_SCALE_ASSERT_SVH
`ifndef ASSERT_OFF
`define TSAS_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define TSAS_ASSERT(lbl, prop, msg) \
  `TSAS_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)
`else
`define TSAS_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define TSAS_ASSERT(lbl, prop, msg)
`endif
`endif

// ===== rtl/tsas_pkg.sv =====
// ----------------------------------------------------------------------------
// Touch sample average and scale package
// Widths, reset values, register indexes, states and controller interfaces.
// ----------------------------------------------------------------------------
package tsas_pkg;

  localparam int unsigned DEF_SAMPLES = 16;
  localparam int unsigned RAW_W       = 16;
  localparam int unsigned POS_W       = 12;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [RAW_W-1:0] RST_RAW_MIN = 16'd0;
  localparam logic [RAW_W-1:0] RST_RAW_MAX = 16'hFFFF;
  localparam logic [POS_W-1:0] RST_SPAN_X  = 12'd240;
  localparam logic [POS_W-1:0] RST_SPAN_Y  = 12'd320;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RAW_MIN_X = 3'd0,
    CFG_RAW_MAX_X = 3'd1,
    CFG_RAW_MIN_Y = 3'd2,
    CFG_RAW_MAX_Y = 3'd3,
    CFG_SPAN_X    = 3'd4,
    CFG_SPAN_Y    = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SCL_GO,
    ST_SCL_RUN,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic acc;
    logic clr;
    logic div_start;
    logic mul_load;
    logic load_out;
    logic ok;
  } ctrl_cmd_t;

  typedef struct packed {
    logic last;
    logic div_done;
  } ctrl_sts_t;

endpackage

// ===== rtl/tsas_div.sv =====
// ----------------------------------------------------------------------------
// Iterative unsigned divider
// Restoring division, one quotient bit per cycle, quotient held after done.
// ----------------------------------------------------------------------------
module tsas_div #(
  parameter int unsigned NUM_W = 28,
  parameter int unsigned DEN_W = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [NUM_W-1:0] quot_o,
  output logic             done_o
);

  localparam int unsigned CW = (NUM_W > 1) ? $clog2(NUM_W) : 1;

  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W+1:0] diff;
  logic             ge;

  always_comb begin
    rem_sh = {rem_q, quo_q[NUM_W-1]};
    diff   = {1'b0, rem_sh} - {2'b00, den_q};
    ge     = ~diff[DEN_W+1];
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      cnt_d  = CW'(NUM_W - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[NUM_W-2:0], ge};
      rem_d = ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign quot_o = quo_q;
  assign done_o = done_q;

endmodule

// ===== rtl/tsas_axis.sv =====
// ----------------------------------------------------------------------------
// Touch axis datapath
// Running sum, shift average, clamp, span multiply and scaling divide.
// ----------------------------------------------------------------------------
module tsas_axis #(
  parameter int unsigned SAMPLES = tsas_pkg::DEF_SAMPLES
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  tsas_pkg::ctrl_cmd_t        cmd_i,
  input  logic [tsas_pkg::RAW_W-1:0] sample_i,
  input  logic [tsas_pkg::RAW_W-1:0] lo_i,
  input  logic [tsas_pkg::RAW_W-1:0] hi_i,
  input  logic [tsas_pkg::POS_W-1:0] span_i,
  output logic [tsas_pkg::POS_W-1:0] pos_o,
  output logic                       done_o
);

  localparam int unsigned SUM_W  = tsas_pkg::RAW_W + $clog2(SAMPLES);
  localparam int unsigned PROD_W = tsas_pkg::RAW_W + tsas_pkg::POS_W;

  logic [SUM_W-1:0]          sum_q, sum_d;
  logic [PROD_W-1:0]         prod_q, quot;
  logic [tsas_pkg::RAW_W-1:0] div_den, avg, lifted, clamped, offs;

  always_comb begin
    sum_d = sum_q;
    if (cmd_i.clr) begin
      sum_d = '0;
    end else if (cmd_i.acc) begin
      sum_d = sum_q + SUM_W'(sample_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else begin
      sum_q <= sum_d;
    end
  end

  // SAMPLES is a power of two, so the average is the upper part of the sum.
  assign avg     = sum_q[SUM_W-1 -: tsas_pkg::RAW_W];
  assign lifted  = (avg < lo_i) ? lo_i : avg;
  assign clamped = (lifted > hi_i) ? hi_i : lifted;
  assign offs    = clamped - lo_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_load) begin
      prod_q <= PROD_W'(offs) * PROD_W'(span_i);
    end
  end

  assign div_den = hi_i - lo_i;

  tsas_div #(
    .NUM_W (PROD_W),
    .DEN_W (tsas_pkg::RAW_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (prod_q),
    .den_i   (div_den),
    .quot_o  (quot),
    .done_o  (done_o)
  );

  assign pos_o = (hi_i > lo_i) ? quot[tsas_pkg::POS_W-1:0] : '0;

endmodule

// ===== rtl/tsas_datapath.sv =====
// ----------------------------------------------------------------------------
// Touch sample datapath
// Configuration registers, sample counter, two axis lanes and result register.
// ----------------------------------------------------------------------------
module tsas_datapath #(
  parameter int unsigned SAMPLES = tsas_pkg::DEF_SAMPLES
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  tsas_pkg::ctrl_cmd_t             cmd_i,
  output tsas_pkg::ctrl_sts_t             sts_o,
  input  logic [tsas_pkg::RAW_W-1:0]      sample_x_i,
  input  logic [tsas_pkg::RAW_W-1:0]      sample_y_i,
  input  logic                            cfg_we_i,
  input  logic [tsas_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tsas_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic                            touch_ok_o,
  output logic [tsas_pkg::POS_W-1:0]      pos_x_o,
  output logic [tsas_pkg::POS_W-1:0]      pos_y_o
);

  localparam int unsigned CNT_W = $clog2(SAMPLES);

  logic [tsas_pkg::RAW_W-1:0] min_x_q, max_x_q, min_y_q, max_y_q;
  logic [tsas_pkg::POS_W-1:0] span_x_q, span_y_q;
  logic [CNT_W-1:0]           taken_q;
  logic [tsas_pkg::POS_W-1:0] pos_x, pos_y;
  logic                       done_x, done_y;
  logic                       touch_ok_q;
  logic [tsas_pkg::POS_W-1:0] pos_x_q, pos_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_x_q  <= tsas_pkg::RST_RAW_MIN;
      max_x_q  <= tsas_pkg::RST_RAW_MAX;
      min_y_q  <= tsas_pkg::RST_RAW_MIN;
      max_y_q  <= tsas_pkg::RST_RAW_MAX;
      span_x_q <= tsas_pkg::RST_SPAN_X;
      span_y_q <= tsas_pkg::RST_SPAN_Y;
    end else if (cfg_we_i) begin
      unique case (tsas_pkg::cfg_idx_e'(cfg_idx_i))
        tsas_pkg::CFG_RAW_MIN_X: min_x_q  <= cfg_data_i;
        tsas_pkg::CFG_RAW_MAX_X: max_x_q  <= cfg_data_i;
        tsas_pkg::CFG_RAW_MIN_Y: min_y_q  <= cfg_data_i;
        tsas_pkg::CFG_RAW_MAX_Y: max_y_q  <= cfg_data_i;
        tsas_pkg::CFG_SPAN_X:    span_x_q <= cfg_data_i[tsas_pkg::POS_W-1:0];
        tsas_pkg::CFG_SPAN_Y:    span_y_q <= cfg_data_i[tsas_pkg::POS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taken_q <= '0;
    end else if (cmd_i.clr) begin
      taken_q <= '0;
    end else if (cmd_i.acc) begin
      taken_q <= taken_q + CNT_W'(1);
    end
  end

  tsas_axis #(.SAMPLES (SAMPLES)) u_axis_x (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd_i),
    .sample_i (sample_x_i),
    .lo_i     (min_x_q),
    .hi_i     (max_x_q),
    .span_i   (span_x_q),
    .pos_o    (pos_x),
    .done_o   (done_x)
  );

  tsas_axis #(.SAMPLES (SAMPLES)) u_axis_y (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd_i),
    .sample_i (sample_y_i),
    .lo_i     (min_y_q),
    .hi_i     (max_y_q),
    .span_i   (span_y_q),
    .pos_o    (pos_y),
    .done_o   (done_y)
  );

  assign sts_o.last     = (taken_q == CNT_W'(SAMPLES - 1));
  assign sts_o.div_done = done_x & done_y;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      touch_ok_q <= cmd_i.ok;
      pos_x_q    <= cmd_i.ok ? pos_x : '0;
      pos_y_q    <= cmd_i.ok ? pos_y : '0;
    end
  end

  assign touch_ok_o = touch_ok_q;
  assign pos_x_o    = pos_x_q;
  assign pos_y_o    = pos_y_q;

endmodule

// ===== rtl/tsas_ctrl.sv =====
// ----------------------------------------------------------------------------
// Touch sample controller
// Sequences accumulation, the scaling divide pass and the result register.
// ----------------------------------------------------------------------------
`include "touch_sample_average_scale_assert.svh"

module tsas_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                pressed_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tsas_pkg::ctrl_cmd_t cmd_o,
  input  tsas_pkg::ctrl_sts_t sts_i
);

  tsas_pkg::state_e    state_q, state_d;
  logic                fail_q, fail_d;
  logic                out_valid_q, out_valid_d;
  tsas_pkg::ctrl_cmd_t cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tsas_pkg::ST_IDLE;
      fail_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fail_q      <= fail_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    fail_d     = fail_q;
    cmd        = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      tsas_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (!pressed_i) begin
            cmd.clr = 1'b1;
            fail_d  = 1'b1;
            state_d = tsas_pkg::ST_RESULT;
          end else begin
            cmd.acc = 1'b1;
            if (sts_i.last) begin
              fail_d  = 1'b0;
              state_d = tsas_pkg::ST_MUL;
            end
          end
        end
      end
      tsas_pkg::ST_MUL: begin
        cmd.mul_load = 1'b1;
        state_d      = tsas_pkg::ST_SCL_GO;
      end
      tsas_pkg::ST_SCL_GO: begin
        cmd.div_start = 1'b1;
        state_d       = tsas_pkg::ST_SCL_RUN;
      end
      tsas_pkg::ST_SCL_RUN: begin
        if (sts_i.div_done) begin
          state_d = tsas_pkg::ST_RESULT;
        end
      end
      tsas_pkg::ST_RESULT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd.load_out = 1'b1;
          cmd.ok       = ~fail_q;
          cmd.clr      = 1'b1;
          state_d      = tsas_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tsas_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign cmd_o       = cmd;
  assign out_valid_o = out_valid_q;

  `TSAS_ASSERT(a_load_free, cmd.load_out |-> (!out_valid_q || out_ready_i), "result overwritten")
  `TSAS_ASSERT(a_start_pulse, cmd.div_start |=> !cmd.div_start, "divider started twice")
  `TSAS_ASSERT(a_release_result, (in_valid_i && in_ready_o && !pressed_i) |=> (state_q == tsas_pkg::ST_RESULT && fail_q), "release not reported")
  `TSAS_ASSERT(a_done_in_run, sts_i.div_done |-> (state_q == tsas_pkg::ST_SCL_RUN), "stray divider done")

endmodule

// ===== rtl/touch_sample_average_scale.sv =====
// ----------------------------------------------------------------------------
// Touch sample average and scale
// Averages pressed touch samples and maps them linearly onto screen pixels.
// ----------------------------------------------------------------------------
// The input channel takes one touch sample per transaction: a pressed flag and
// raw X and Y readings. The output channel gives one transaction per finished
// touch: a valid flag and scaled X and Y coordinates, or a failure with zero
// coordinates when a sample arrives with the pressed flag low.
// A pressed sample that is not the last of a group gives no output. A release
// sample moves the controller to its result state, which loads the failure
// result into the output register once that register is free; the controller
// then returns to idle for the next sample. The last sample of a group of
// SAMPLES, a power of two, averages each axis by a shift and runs the span
// product of each axis through its own bit-serial divider over 28 bits: the
// controller forms the product, starts the divider, waits while it gives one
// quotient bit per step, and then loads the output register once it is free.
// The input channel is stalled meanwhile. It takes a new sample while a
// result waits in the output register, but stops taking samples once a new
// result is ready and the receiver stalls. Reset clears the sums, the sample
// count and the output valid flag and returns the configuration registers to
// their defaults.
// ----------------------------------------------------------------------------
module touch_sample_average_scale #(
  parameter int unsigned SAMPLES = tsas_pkg::DEF_SAMPLES
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            pressed_i,
  input  logic [tsas_pkg::RAW_W-1:0]      sample_x_i,
  input  logic [tsas_pkg::RAW_W-1:0]      sample_y_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            touch_ok_o,
  output logic [tsas_pkg::POS_W-1:0]      pos_x_o,
  output logic [tsas_pkg::POS_W-1:0]      pos_y_o,
  input  logic                            cfg_we_i,
  input  logic [tsas_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tsas_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  tsas_pkg::ctrl_cmd_t cmd;
  tsas_pkg::ctrl_sts_t sts;

  tsas_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .pressed_i   (pressed_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  tsas_datapath #(.SAMPLES (SAMPLES)) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .sample_x_i (sample_x_i),
    .sample_y_i (sample_y_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .touch_ok_o (touch_ok_o),
    .pos_x_o    (pos_x_o),
    .pos_y_o    (pos_y_o)
  );

endmodule

// ===== tb/touch_sample_average_scale_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Touch sample average and scale testbench
// Drives touch samples through the input channel, predicts each averaged and
// calibrated result in a behavioral model kept alongside, and compares every
// output transaction against it across several calibration windows.
// ----------------------------------------------------------------------------
module touch_sample_average_scale_tb;

  localparam int unsigned RESET_CYCLES  = 9;
  localparam int unsigned PHASES        = 10;
  localparam int unsigned PHASE_ITEMS   = 100;
  localparam int unsigned SETTLE_CYCLES = 80;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned HOLD_PHASE    = 6;
  localparam int unsigned CALM_PHASE    = 4;
  localparam int unsigned STALL_LIMIT   = 5000;
  localparam int unsigned IDLE_PCT      = 17;
  localparam int unsigned REPORT_MAX    = 10;

  typedef struct {
    logic                       ok;
    logic [tsas_pkg::POS_W-1:0] x;
    logic [tsas_pkg::POS_W-1:0] y;
  } touch_t;

  typedef struct {
    logic                       pressed;
    logic [tsas_pkg::RAW_W-1:0] sx;
    logic [tsas_pkg::RAW_W-1:0] sy;
    bit                         typed;
    touch_t                     want;
  } row_t;

  logic                            clk_i       = 1'b0;
  logic                            rst_ni      = 1'b0;
  logic                            in_valid_i  = 1'b0;
  logic                            in_ready_o;
  logic                            pressed_i   = 1'b0;
  logic [tsas_pkg::RAW_W-1:0]      sample_x_i  = '0;
  logic [tsas_pkg::RAW_W-1:0]      sample_y_i  = '0;
  logic                            out_valid_o;
  logic                            out_ready_i = 1'b0;
  logic                            touch_ok_o;
  logic [tsas_pkg::POS_W-1:0]      pos_x_o;
  logic [tsas_pkg::POS_W-1:0]      pos_y_o;
  logic                            cfg_we_i    = 1'b0;
  logic [tsas_pkg::CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [tsas_pkg::CFG_DATA_W-1:0] cfg_data_i  = '0;

  logic [tsas_pkg::RAW_W-1:0] win_min_x = tsas_pkg::RST_RAW_MIN;
  logic [tsas_pkg::RAW_W-1:0] win_max_x = tsas_pkg::RST_RAW_MAX;
  logic [tsas_pkg::RAW_W-1:0] win_min_y = tsas_pkg::RST_RAW_MIN;
  logic [tsas_pkg::RAW_W-1:0] win_max_y = tsas_pkg::RST_RAW_MAX;
  logic [tsas_pkg::POS_W-1:0] width_px  = tsas_pkg::RST_SPAN_X;
  logic [tsas_pkg::POS_W-1:0] height_px = tsas_pkg::RST_SPAN_Y;
  logic [31:0]                acc_x     = '0;
  logic [31:0]                acc_y     = '0;
  int unsigned                acc_count = 0;

  touch_t      pos_expect_q[$];
  touch_t      blank_touch;
  int unsigned items_sent   = 0;
  int unsigned fault_cnt    = 0;
  int unsigned ok_seen      = 0;
  int unsigned release_seen = 0;
  bit          calm         = 1'b0;
  bit          hold_req     = 1'b0;

  touch_sample_average_scale #(
    .SAMPLES(tsas_pkg::DEF_SAMPLES)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .pressed_i  (pressed_i),
    .sample_x_i (sample_x_i),
    .sample_y_i (sample_y_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .touch_ok_o (touch_ok_o),
    .pos_x_o    (pos_x_o),
    .pos_y_o    (pos_y_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [tsas_pkg::POS_W-1:0] calibrate_axis(
      input logic [31:0]                sum,
      input logic [tsas_pkg::RAW_W-1:0] lo,
      input logic [tsas_pkg::RAW_W-1:0] hi,
      input logic [tsas_pkg::POS_W-1:0] span);
    logic [31:0] avg;
    logic [31:0] scaled;
    avg = sum / tsas_pkg::DEF_SAMPLES;
    if (avg < lo) avg = lo;
    if (avg > hi) avg = hi;
    if (hi <= lo) return '0;
    scaled = (avg - lo) * span / (hi - lo);
    return scaled[tsas_pkg::POS_W-1:0];
  endfunction

  function automatic void advance_touch(input logic pressed,
                                        input logic [tsas_pkg::RAW_W-1:0] sx,
                                        input logic [tsas_pkg::RAW_W-1:0] sy,
                                        output bit has, output touch_t res);
    res.ok = 1'b0;
    res.x  = '0;
    res.y  = '0;
    has    = 1'b0;
    if (!pressed) begin
      acc_x     = '0;
      acc_y     = '0;
      acc_count = 0;
      has       = 1'b1;
      return;
    end
    acc_x     = acc_x + sx;
    acc_y     = acc_y + sy;
    acc_count = acc_count + 1;
    if (acc_count < tsas_pkg::DEF_SAMPLES) return;
    res.ok    = 1'b1;
    res.x     = calibrate_axis(acc_x, win_min_x, win_max_x, width_px);
    res.y     = calibrate_axis(acc_y, win_min_y, win_max_y, height_px);
    has       = 1'b1;
    acc_x     = '0;
    acc_y     = '0;
    acc_count = 0;
  endfunction

  function automatic row_t make_row(input logic pressed,
                                    input logic [tsas_pkg::RAW_W-1:0] sx,
                                    input logic [tsas_pkg::RAW_W-1:0] sy,
                                    input bit typed, input logic ok,
                                    input logic [tsas_pkg::POS_W-1:0] x,
                                    input logic [tsas_pkg::POS_W-1:0] y);
    row_t r;
    r.pressed = pressed;
    r.sx      = sx;
    r.sy      = sy;
    r.typed   = typed;
    r.want.ok = ok;
    r.want.x  = x;
    r.want.y  = y;
    return r;
  endfunction

  task automatic send_sample(input logic pressed, input logic [tsas_pkg::RAW_W-1:0] sx,
                             input logic [tsas_pkg::RAW_W-1:0] sy, input bit typed,
                             input touch_t want);
    bit     has;
    touch_t res;
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pressed_i  <= pressed;
    sample_x_i <= sx;
    sample_y_i <= sy;
    do @(posedge clk_i); while (!in_ready_o);
    advance_touch(pressed, sx, sy, has, res);
    if (typed) pos_expect_q.push_back(want);
    else if (has) pos_expect_q.push_back(res);
    items_sent++;
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pos_expect_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input tsas_pkg::cfg_idx_e idx,
                           input logic [tsas_pkg::CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      tsas_pkg::CFG_RAW_MIN_X: win_min_x = data;
      tsas_pkg::CFG_RAW_MAX_X: win_max_x = data;
      tsas_pkg::CFG_RAW_MIN_Y: win_min_y = data;
      tsas_pkg::CFG_RAW_MAX_Y: win_max_y = data;
      tsas_pkg::CFG_SPAN_X:    width_px  = data[tsas_pkg::POS_W-1:0];
      tsas_pkg::CFG_SPAN_Y:    height_px = data[tsas_pkg::POS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_window(input logic [tsas_pkg::RAW_W-1:0] lox,
                                input logic [tsas_pkg::RAW_W-1:0] hix,
                                input logic [tsas_pkg::RAW_W-1:0] loy,
                                input logic [tsas_pkg::RAW_W-1:0] hiy,
                                input logic [tsas_pkg::POS_W-1:0] spx,
                                input logic [tsas_pkg::POS_W-1:0] spy);
    write_reg(tsas_pkg::CFG_RAW_MIN_X, lox);
    write_reg(tsas_pkg::CFG_RAW_MAX_X, hix);
    write_reg(tsas_pkg::CFG_RAW_MIN_Y, loy);
    write_reg(tsas_pkg::CFG_RAW_MAX_Y, hiy);
    write_reg(tsas_pkg::CFG_SPAN_X, tsas_pkg::CFG_DATA_W'(spx));
    write_reg(tsas_pkg::CFG_SPAN_Y, tsas_pkg::CFG_DATA_W'(spy));
    cfg_we_i <= 1'b0;
  endtask

  // Most bursts are complete touches; the rest are cut short by a release or
  // are a lone release.
  task automatic send_touch_burst();
    int unsigned                kind;
    int unsigned                style;
    int unsigned                count;
    logic [tsas_pkg::RAW_W-1:0] base_x;
    logic [tsas_pkg::RAW_W-1:0] base_y;
    logic [tsas_pkg::RAW_W-1:0] sx;
    logic [tsas_pkg::RAW_W-1:0] sy;
    kind   = $urandom_range(99);
    style  = $urandom_range(2);
    base_x = 16'($urandom());
    base_y = 16'($urandom());
    if (kind < 75) count = tsas_pkg::DEF_SAMPLES;
    else if (kind < 90) count = $urandom_range(1, tsas_pkg::DEF_SAMPLES - 1);
    else count = 0;
    for (int i = 0; i < count; i++) begin
      case (style)
        0: begin
          sx = 16'($urandom());
          sy = 16'($urandom());
        end
        1: begin
          sx = base_x ^ {8'h00, 8'($urandom())};
          sy = base_y ^ {8'h00, 8'($urandom())};
        end
        default: begin
          sx = $urandom_range(1) ? 16'hFFFF : 16'h0000;
          sy = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        end
      endcase
      send_sample(1'b1, sx, sy, 1'b0, blank_touch);
    end
    if (kind >= 75) send_sample(1'b0, 16'($urandom()), 16'($urandom()), 1'b0, blank_touch);
  endtask

  initial begin
    forever begin
      @(posedge clk_i);
      if (!rst_ni) begin
        out_ready_i <= 1'b0;
      end else if (hold_req) begin
        out_ready_i <= 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        out_ready_i <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk_i) begin
    touch_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pos_expect_q.size() == 0) begin
        if (fault_cnt < REPORT_MAX)
          $display("Unexpected result transaction: ok=%0d x=%0d y=%0d",
                   touch_ok_o, pos_x_o, pos_y_o);
        fault_cnt++;
      end else begin
        want = pos_expect_q.pop_front();
        if (touch_ok_o !== want.ok || pos_x_o !== want.x || pos_y_o !== want.y) begin
          if (fault_cnt < REPORT_MAX)
            $display("Mismatch: expected ok=%0d x=%0d y=%0d, got ok=%0d x=%0d y=%0d",
                     want.ok, want.x, want.y, touch_ok_o, pos_x_o, pos_y_o);
          fault_cnt++;
        end
        if (want.ok) ok_seen++;
        else release_seen++;
      end
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) quiet = 0;
      else quiet++;
    end
    $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
    $display("FAILURE");
    $finish;
  end

  initial begin
    row_t                       script[$];
    int unsigned                start;
    int unsigned                leftover;
    logic [tsas_pkg::RAW_W-1:0] lox;
    logic [tsas_pkg::RAW_W-1:0] hix;
    logic [tsas_pkg::RAW_W-1:0] loy;
    logic [tsas_pkg::RAW_W-1:0] hiy;
    logic [tsas_pkg::POS_W-1:0] spx;
    logic [tsas_pkg::POS_W-1:0] spy;

    blank_touch.ok = 1'b0;
    blank_touch.x  = '0;
    blank_touch.y  = '0;

    // A release before any sample, a full touch at the panel corner, and a
    // touch released early.
    script.push_back(make_row(1'b0, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0, '0, '0));
    for (int i = 0; i < tsas_pkg::DEF_SAMPLES - 1; i++)
      script.push_back(make_row(1'b1, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, '0, '0));
    script.push_back(make_row(1'b1, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1,
                              tsas_pkg::RST_SPAN_X, tsas_pkg::RST_SPAN_Y));
    for (int i = 0; i < 3; i++)
      script.push_back(make_row(1'b1, 16'h0000, 16'h0000, 1'b0, 1'b0, '0, '0));
    script.push_back(make_row(1'b0, 16'h0000, 16'h0000, 1'b1, 1'b0, '0, '0));

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[i])
      send_sample(script[i].pressed, script[i].sx, script[i].sy, script[i].typed,
                  script[i].want);

    for (int phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      case (phase)
        0: program_window(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 12'hFFF, 12'hFFF);
        1: program_window(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 12'h000, 12'h000);
        2: program_window(16'h8000, 16'h7FFF, 16'h1234, 16'h1234,
                          12'($urandom()), 12'($urandom()));
        3: program_window(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0001, 12'hFFF, 12'hFFF);
        default: begin
          lox = 16'($urandom());
          hix = $urandom_range(1) ? 16'($urandom()) : lox + 16'($urandom_range(4096));
          loy = 16'($urandom());
          hiy = $urandom_range(1) ? 16'($urandom()) : loy + 16'($urandom_range(4096));
          spx = ($urandom_range(4) == 0) ? 12'hFFF : 12'($urandom());
          spy = ($urandom_range(4) == 0) ? 12'hFFF : 12'($urandom());
          program_window(lox, hix, loy, hiy, spx, spy);
        end
      endcase
      calm = (phase == CALM_PHASE);
      if (phase == HOLD_PHASE) hold_req = 1'b1;
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) send_touch_burst();
    end

    in_valid_i <= 1'b0;
    while (pos_expect_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    leftover = pos_expect_q.size();
    if (leftover != 0) $display("%0d expected results never arrived", leftover);

    $display("Sent %0d touch samples under %0d calibration windows, with one long output stall.",
             items_sent, PHASES + 1);
    $display("Checked %0d coordinate results and %0d release results.",
             ok_seen, release_seen);
    if (fault_cnt == 0 && leftover == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
